### design/assert_macros.svh
// Assertion helpers used by the RTL top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/hsvba_pkg.sv
// ----------------------------------------------------------------------------
// hsvba_pkg: shared types for the HSV brightness adjust block
// Holds the pixel payload types and the command codes.
// ----------------------------------------------------------------------------
package hsvba_pkg;

  typedef enum logic {
    CMD_DARKER  = 1'b0,
    CMD_LIGHTER = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic [8:0] amount;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  localparam int unsigned AmountMax = 256;

endpackage

### design/hsvba_in_if.sv
// ----------------------------------------------------------------------------
// hsvba_in_if: input pixel channel
// Valid/ready handshake carrying one input pixel beat.
// ----------------------------------------------------------------------------
interface hsvba_in_if;
  import hsvba_pkg::*;
  logic    valid;
  logic    ready;
  pix_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/hsvba_out_if.sv
// ----------------------------------------------------------------------------
// hsvba_out_if: output pixel channel
// Valid/ready handshake carrying one result pixel beat.
// ----------------------------------------------------------------------------
interface hsvba_out_if;
  import hsvba_pkg::*;
  logic     valid;
  logic     ready;
  pix_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/hsv_brightness_adjust_top.sv
// ----------------------------------------------------------------------------
// hsv_brightness_adjust_top: HSV darken / lighten of an RGBA pixel stream
// Converts each pixel to fixed-point HSV, adjusts value (lighter overflow lowers saturation), converts back.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : sink channel, one RGBA pixel plus cmd and amount per beat.
//   out_if : source channel, one adjusted RGBA pixel per beat.
//   A beat moves at a rising edge with valid and ready both high.
// Throughput: one pixel per cycle, sustained, with no bubbles, while out_if ready stays high.
// Depth: 12 register stages. The depth is set by the two restoring
//   dividers (hue and saturation), which retire the integer quotient bit
//   and FRAC_BITS/2 fraction bits in the first divider stage and the
//   rest in the second, and by the back-conversion multiplier chain,
//   each multiply with its own register.
// Stall: the whole pipeline advances on one enable; when the receiver drops
//   ready and the output register is full, every stage holds, and in_if
//   ready falls. A beat sits in the output register while the next is held.
// Reset: rst_ni (asynchronous, active low) clears all valid bits; payload
//   registers are not reset. The block is ready for a beat as soon as
//   reset is released.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_brightness_adjust_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  hsvba_in_if.sink    in_if,
  hsvba_out_if.source out_if
);
  import hsvba_pkg::*;

  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned HALF = FB / 2;
  localparam int unsigned REST = FB - HALF;
  localparam int unsigned NST  = 12;
  localparam int unsigned FW   = FB + 1;   // values 0..UNIT
  localparam logic [FW-1:0] UNIT = FW'(1) << FB;
  localparam int unsigned HW   = FB + 3;   // hue position, up to 6*UNIT
  // UNIT = 255*VK + VR, with VR = 2^(FB mod 8) since 256 is 1 mod 255.
  localparam int unsigned VR   = 1 << (FB % 8);
  localparam int unsigned VK   = ((1 << FB) - VR) / 255;
  // floor(t/255) = (t*RCP) >> 24 for every t below 2^16.
  localparam logic [16:0] RCP  = 17'd65794;

  // Stage enable: advance whenever the last stage can drain.
  logic [NST-1:0] vld_q;
  logic           adv;
  assign adv          = !vld_q[NST-1] || out_if.ready;
  assign in_if.ready  = adv;
  assign out_if.valid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_if.valid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Max, min, hue case selection, clamp amount.
  logic [7:0] mx1_q, d1_q, hn1_q, a1_q;
  logic [1:0] hsel1_q;   // base sector 0,2,4 as 0,1,2
  logic       hneg1_q, cmd1_q;
  logic [8:0] amt1_q;

  always_ff @(posedge clk_i) begin
    logic [7:0] r, g, b, mx, mn;
    r = in_if.data.red_in;
    g = in_if.data.green_in;
    b = in_if.data.blue_in;
    if (adv) begin
      mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
      mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
      mx1_q <= mx;
      d1_q  <= mx - mn;
      if (mx == r) begin
        hsel1_q <= 2'd0; hneg1_q <= (g < b); hn1_q <= (g >= b) ? g - b : b - g;
      end else if (mx == g) begin
        hsel1_q <= 2'd1; hneg1_q <= (b < r); hn1_q <= (b >= r) ? b - r : r - b;
      end else begin
        hsel1_q <= 2'd2; hneg1_q <= (r < g); hn1_q <= (r >= g) ? r - g : g - r;
      end
      cmd1_q <= in_if.data.cmd;
      a1_q   <= in_if.data.alpha_in;
      amt1_q <= (in_if.data.amount > 9'(AmountMax)) ? 9'(AmountMax) : in_if.data.amount;
    end
  end

  // ---------------------------------------------------------- stages 2..3
  // Two restoring dividers of 8-bit dividend shifted by FB, by 8-bit
  // divisor: hue q = hn*UNIT/d, s = d*UNIT/mx.
  // Stage 2 retires the integer bit and HALF fraction bits, stage 3 the REST.
  // Remainders fit in 8 bits (below the divisor), quotient in FB+1 bits.
  // v = (mx*UNIT+254)/255 = mx*VK + (mx*VR+254)/255, done in stage 2.
  typedef struct packed {
    logic [8:0]    rem;
    logic [FB:0]   quo;
  } div_t;

  function automatic div_t div_steps(div_t st, logic [7:0] den, int unsigned n,
                                     logic [FB+7:0] num, int unsigned pos);
    div_t o;
    logic [9:0] t;
    o = st;
    for (int i = 0; i < n; i++) begin
      t = {o.rem, num[pos-1-i]};
      o.quo = {o.quo[FB-1:0], 1'b0};
      if (t >= {2'b0, den}) begin
        t = t - {2'b0, den};
        o.quo[0] = 1'b1;
      end
      o.rem = t[8:0];
    end
    return o;
  endfunction

  // Integer part (8 dividend bits, quotient <= 1 bit) done first: quotient
  // of an 8-bit by larger-or-equal divisor is 0 or 1, remainder directly.
  function automatic div_t div_int(logic [7:0] num, logic [7:0] den);
    div_t o;
    o.quo = '0;
    if (den != 8'd0 && num >= den) begin
      o.quo[0] = 1'b1;
      o.rem    = {1'b0, num - den};
    end else begin
      o.rem    = {1'b0, num};
    end
    return o;
  endfunction

  div_t hq2_q, sq2_q, hq3_q, sq3_q;
  logic [FW-1:0] v2_q, v3_q;
  logic [7:0] mx2_q, d2_q, mx3_q, d3_q, a2_q, a3_q;
  logic [1:0] hsel2_q, hsel3_q;
  logic       hneg2_q, hneg3_q, cmd2_q, cmd3_q;
  logic [8:0] amt2_q, amt3_q;
  logic [FB+7:0] zero_num;
  assign zero_num = '0;

  always_ff @(posedge clk_i) begin
    logic [15:0] vt;
    logic [32:0] vp;
    if (adv) begin
      // Remainder part of v by reciprocal multiply.
      vt = 16'(mx1_q) * 16'(VR) + 16'd254;
      vp = 33'(vt) * 33'(RCP);
      v2_q  <= FW'(mx1_q) * FW'(VK) + FW'(vp >> 24);
      hq2_q <= div_steps(div_int(hn1_q, d1_q), d1_q, HALF, zero_num, FB);
      sq2_q <= div_steps(div_int(d1_q, mx1_q), mx1_q, HALF, zero_num, FB);
      mx2_q <= mx1_q; d2_q <= d1_q; a2_q <= a1_q;
      hsel2_q <= hsel1_q; hneg2_q <= hneg1_q; cmd2_q <= cmd1_q; amt2_q <= amt1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hq3_q <= div_steps(hq2_q, d2_q, REST, zero_num, REST);
      sq3_q <= div_steps(sq2_q, mx2_q, REST, zero_num, REST);
      v3_q  <= v2_q;
      mx3_q <= mx2_q; d3_q <= d2_q; a3_q <= a2_q;
      hsel3_q <= hsel2_q; hneg3_q <= hneg2_q; cmd3_q <= cmd2_q; amt3_q <= amt2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Assemble hue, zero for grey; zero saturation for black; delta product.
  logic [HW-1:0] h4_q;
  logic [FW-1:0] s4_q, v4_q;
  logic [FW+8:0] dp4_q;
  logic          cmd4_q;
  logic [7:0]    a4_q;

  always_ff @(posedge clk_i) begin
    logic [HW-1:0] base, q;
    if (adv) begin
      base = HW'(hsel3_q) * (HW'(2) << FB);
      q    = HW'(hq3_q.quo);
      if (d3_q == 8'd0) begin
        h4_q <= '0;
      end else if (hneg3_q) begin
        h4_q <= ((hsel3_q == 2'd0) ? (HW'(6) << FB) : base) - q;
      end else begin
        h4_q <= base + q;
      end
      s4_q  <= (mx3_q == 8'd0) ? '0 : sq3_q.quo;
      v4_q  <= v3_q;
      dp4_q <= v3_q * amt3_q;
      cmd4_q <= cmd3_q; a4_q <= a3_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Apply the adjustment, move the lighter overflow into saturation.
  logic [2:0]    sec5_q;
  logic [FB-1:0] f5_q;
  logic [FW-1:0] s5_q, v5_q;
  logic [7:0]    a5_q;

  always_ff @(posedge clk_i) begin
    logic [FW:0] vn, dl, ex;
    if (adv) begin
      dl = (FW+1)'(dp4_q >> 8);
      sec5_q <= 3'(h4_q >> FB);
      f5_q   <= h4_q[FB-1:0];
      a5_q   <= a4_q;
      if (cmd4_q == CMD_LIGHTER) begin
        vn = {1'b0, v4_q} + dl;
        if (vn > {1'b0, UNIT}) begin
          ex   = vn - {1'b0, UNIT};
          s5_q <= ({1'b0, s4_q} > ex) ? FW'({1'b0, s4_q} - ex) : '0;
          v5_q <= UNIT;
        end else begin
          s5_q <= s4_q;
          v5_q <= FW'(vn);
        end
      end else begin
        s5_q <= s4_q;
        v5_q <= v4_q - FW'(dl);
      end
    end
  end

  // ---------------------------------------------------------------- stage 6
  // f*s and (UNIT-f)*s, and UNIT-s.
  logic [2*FW-1:0] fs6_q, gs6_q;
  logic [FW-1:0]   ns6_q, v6_q;
  logic [2:0]      sec6_q;
  logic [7:0]      a6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fs6_q  <= {1'b0, f5_q} * s5_q;
      gs6_q  <= (UNIT - {1'b0, f5_q}) * s5_q;
      ns6_q  <= UNIT - s5_q;
      v6_q   <= v5_q; sec6_q <= sec5_q; a6_q <= a5_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  logic [FW-1:0] ny7_q, nz7_q, ns7_q, v7_q;
  logic [2:0]    sec7_q;
  logic [7:0]    a7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ny7_q <= UNIT - FW'(fs6_q >> FB);
      nz7_q <= UNIT - FW'(gs6_q >> FB);
      ns7_q <= ns6_q; v7_q <= v6_q; sec7_q <= sec6_q; a7_q <= a6_q;
    end
  end

  // ---------------------------------------------------------------- stage 8
  logic [2*FW-1:0] x8_q, y8_q, z8_q;
  logic [FW-1:0]   v8_q;
  logic [2:0]      sec8_q;
  logic [7:0]      a8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x8_q <= v7_q * ns7_q;
      y8_q <= v7_q * ny7_q;
      z8_q <= v7_q * nz7_q;
      v8_q <= v7_q; sec8_q <= sec7_q; a8_q <= a7_q;
    end
  end

  // ---------------------------------------------------------------- stage 9
  // Sector routing of v, x, y, z onto the channels.
  logic [FW-1:0] cr9_q, cg9_q, cb9_q;
  logic [7:0]    a9_q;

  always_ff @(posedge clk_i) begin
    logic [FW-1:0] x, y, z;
    if (adv) begin
      x = FW'(x8_q >> FB);
      y = FW'(y8_q >> FB);
      z = FW'(z8_q >> FB);
      case (sec8_q)
        3'd1:    begin cr9_q <= y;    cg9_q <= v8_q; cb9_q <= x;    end
        3'd2:    begin cr9_q <= x;    cg9_q <= v8_q; cb9_q <= z;    end
        3'd3:    begin cr9_q <= x;    cg9_q <= y;    cb9_q <= v8_q; end
        3'd4:    begin cr9_q <= z;    cg9_q <= x;    cb9_q <= v8_q; end
        3'd5:    begin cr9_q <= v8_q; cg9_q <= x;    cb9_q <= y;    end
        default: begin cr9_q <= v8_q; cg9_q <= z;    cb9_q <= x;    end
      endcase
      a9_q <= a8_q;
    end
  end

  // ------------------------------------------------------------ stage 10-11
  // c*255 = (c<<8) - c, then truncate to 8 bits.
  logic [FW+7:0] pr10_q, pg10_q, pb10_q;
  logic [7:0]    a10_q, a11_q;
  logic [7:0]    r11_q, g11_q, b11_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr10_q <= ({cr9_q, 8'd0}) - (FW+8)'(cr9_q);
      pg10_q <= ({cg9_q, 8'd0}) - (FW+8)'(cg9_q);
      pb10_q <= ({cb9_q, 8'd0}) - (FW+8)'(cb9_q);
      a10_q  <= a9_q;
      r11_q  <= pr10_q[FB+7:FB];
      g11_q  <= pg10_q[FB+7:FB];
      b11_q  <= pb10_q[FB+7:FB];
      a11_q  <= a10_q;
    end
  end

  // --------------------------------------------------------- output stage
  pix_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.red_out   <= r11_q;
      out_q.green_out <= g11_q;
      out_q.blue_out  <= b11_q;
      out_q.alpha_out <= a11_q;
    end
  end
  assign out_if.data = out_q;

  // -------------------------------------------------------------- checks
  `ASSERT_CLK(a_hold_on_stall, clk_i, rst_ni,
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.data)),
    "output beat changed while stalled")
  `ASSERT_CLK(a_ready_when_free, clk_i, rst_ni,
    !out_if.valid |-> in_if.ready, "input stalled with empty output")
  `ASSERT_ALWAYS(a_reset_empty, clk_i,
    !rst_ni |=> !out_if.valid, "output valid after reset")

endmodule
